// ===== rtl/rcpf_pkg.sv =====
// rcpf_pkg: shared types and codes for the rc pwm capture and failsafe unit
// used by every module of the block, no dependencies

package rcpf_pkg;

   // number of width fields on the result channel
   localparam int unsigned OUT_CHANNELS = 6;

   // request type codes
   localparam logic REQ_EDGE = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_FAILSAFE = 2'd1;

   // configuration reset values
   localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
   localparam logic [15:0] FAILSAFE_RESET = 16'd10;

   typedef logic [15:0] width_type;
   typedef width_type [OUT_CHANNELS-1:0] width_vec_type;

   // capture status handed to the failsafe logic
   typedef struct packed {
      logic [OUT_CHANNELS-1:0] fresh;
      logic                    any_fresh;
   } cap_status_type;

   // one result item
   typedef struct packed {
      width_vec_type widths;
      logic          link_ok;
      logic          connected;
   } result_type;

endpackage

// ===== rtl/rcpf_capture.sv =====
// rcpf_capture: per-channel edge capture of start times and pulse widths
// depends on rcpf_pkg

module rcpf_capture
   import rcpf_pkg::*;
#(
   parameter int unsigned CHANNELS = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           edge_en,
   input  logic [2:0]     channel,
   input  logic           level,
   input  logic [31:0]    time_us,
   input  logic           clear,
   output width_vec_type  cap_widths,
   output cap_status_type cap_status
);

   logic [OUT_CHANNELS-1:0] fresh_ff;
   logic                    any_fresh_ff;
   logic                    any_fresh_in;
   logic                    fall_hit;

   // a falling edge on any channel in range
   assign fall_hit = edge_en && !level && (channel < 3'(CHANNELS));

   for (genvar j = 0; j < OUT_CHANNELS; j++) begin : g_ch
      if (j < CHANNELS) begin : g_used
         logic [31:0] start_ff, start_in;
         width_type   capt_ff, capt_in;
         logic        fresh_in;
         logic        hit;

         assign hit = edge_en && (channel == 3'(j));

         // rising edge stores the start, falling edge takes the wrapped width, clear zeroes it
         always_comb begin
            start_in = start_ff;
            capt_in  = capt_ff;
            fresh_in = fresh_ff[j];
            if (hit && level) begin
               start_in = time_us;
            end else if (hit && !level) begin
               capt_in  = 16'(time_us - start_ff);
               fresh_in = 1'b1;
            end else if (clear) begin
               capt_in  = '0;
               fresh_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               start_ff    <= '0;
               capt_ff     <= '0;
               fresh_ff[j] <= 1'b0;
            end else begin
               start_ff    <= start_in;
               capt_ff     <= capt_in;
               fresh_ff[j] <= fresh_in;
            end
         end

         assign cap_widths[j] = capt_ff;
      end else begin : g_unused
         assign fresh_ff[j]   = 1'b0;
         assign cap_widths[j] = '0;
      end
   end

   // global fresh flag
   always_comb begin
      any_fresh_in = any_fresh_ff;
      if (fall_hit) begin
         any_fresh_in = 1'b1;
      end else if (clear) begin
         any_fresh_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_fresh_ff <= 1'b0;
      end else begin
         any_fresh_ff <= any_fresh_in;
      end
   end

   assign cap_status.fresh     = fresh_ff;
   assign cap_status.any_fresh = any_fresh_ff;

endmodule

// ===== rtl/rcpf_failsafe.sv =====
// rcpf_failsafe: held widths, pulse poll counter and link timeout decision
// depends on rcpf_pkg

module rcpf_failsafe
   import rcpf_pkg::*;
#(
   parameter int unsigned CHANNELS = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           poll_en,
   input  logic [31:0]    time_ms,
   input  logic [15:0]    timeout_ms,
   input  logic [15:0]    failsafe_value,
   input  width_vec_type  cap_widths,
   input  cap_status_type cap_status,
   output result_type     result
);

   width_vec_type held_ff, held_in;
   logic [15:0]   polls_ff, polls_in;
   logic [31:0]   last_ff, last_in;
   logic          link_ff, link_in;
   logic          ok;
   logic [31:0]   elapsed;
   logic          expired;

   // wrapping time since the last window restart
   assign elapsed = time_ms - last_ff;
   assign expired = elapsed > {16'd0, timeout_ms};

   always_comb begin
      held_in  = held_ff;
      polls_in = polls_ff;
      last_in  = last_ff;
      link_in  = link_ff;
      ok       = 1'b1;
      if (poll_en) begin
         if (cap_status.any_fresh) begin
            // latch fresh widths and count one pulse poll
            for (int j = 0; j < OUT_CHANNELS; j++) begin
               if (cap_status.fresh[j]) begin
                  held_in[j] = cap_widths[j];
               end
            end
            if (polls_ff != 16'hFFFF) begin
               polls_in = polls_ff + 16'd1;
            end
         end else if (expired) begin
            last_in = time_ms;
            if (polls_ff == '0) begin
               // link lost: force failsafe onto the used channels
               for (int j = 0; j < OUT_CHANNELS; j++) begin
                  if (j < CHANNELS) begin
                     held_in[j] = failsafe_value;
                  end
               end
               link_in = 1'b0;
               ok      = 1'b0;
            end else begin
               polls_in = '0;
               link_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         polls_ff <= '0;
         last_ff  <= '0;
         link_ff  <= 1'b0;
      end else begin
         held_ff  <= held_in;
         polls_ff <= polls_in;
         last_ff  <= last_in;
         link_ff  <= link_in;
      end
   end

   // result reflects the state after this poll
   assign result.widths    = held_in;
   assign result.link_ok   = ok;
   assign result.connected = link_in;

endmodule

// ===== rtl/rc_pwm_capture_failsafe_unit.sv =====
// rc_pwm_capture_failsafe_unit: top level of the rc pwm capture and failsafe
// depends on rcpf_pkg, rcpf_capture and rcpf_failsafe
//
// Usage:
//   req_* carries one item: an edge event (req_type edge) with channel,
//   pin level and microsecond time, or a poll (req_type poll) with a
//   millisecond time. Edges give no result; each poll gives one item on
//   rsp_* with six held widths, link_ok and connected.
//   csr_* writes timeout_ms (index 0) and failsafe_value (index 1);
//   csr_ready is always high, other indexes are ignored.
//   An item is registered at the input, processed by the update stage,
//   and a poll's result is registered in the result register that drives
//   rsp_*. Throughput is one item per cycle while no poll is blocked, set
//   by the single update stage between the input and result registers.
//   When rsp_stall holds a result, edges keep flowing; a poll waits in the
//   input register and req_stall rises only while that poll is blocked.
//   Reset clears all captures, held widths, counters and the link state
//   and loads the register defaults 100 and 10.

module rc_pwm_capture_failsafe_unit
   import rcpf_pkg::*;
#(
   parameter int unsigned CHANNELS = 6
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [2:0]  req_channel,
   input  logic        req_level,
   input  logic [31:0] req_time_us,
   input  logic [31:0] req_time_ms,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_ch1_width,
   output logic [15:0] rsp_ch2_width,
   output logic [15:0] rsp_ch3_width,
   output logic [15:0] rsp_ch4_width,
   output logic [15:0] rsp_ch5_width,
   output logic [15:0] rsp_ch6_width,
   output logic        rsp_link_ok,
   output logic        rsp_connected,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic           in_vld_ff;
   logic           type_ff;
   logic [2:0]     channel_ff;
   logic           level_ff;
   logic [31:0]    time_us_ff;
   logic [31:0]    time_ms_ff;
   logic           fire;
   logic           poll_en;
   logic           edge_en;
   logic           req_take;
   logic [15:0]    timeout_ff;
   logic [15:0]    failsafe_ff;
   logic           out_vld_ff;
   result_type     out_ff;
   result_type     result;
   width_vec_type  cap_widths;
   cap_status_type cap_status;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         failsafe_ff <= FAILSAFE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TIMEOUT:  timeout_ff  <= csr_wdata;
            CSR_FAILSAFE: failsafe_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage control: edges always proceed, a poll needs room in the result register
   assign fire      = in_vld_ff && ((type_ff == REQ_EDGE) || !out_vld_ff || !rsp_stall);
   assign poll_en   = fire && (type_ff == REQ_POLL);
   assign edge_en   = fire && (type_ff == REQ_EDGE);
   assign req_stall = in_vld_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_take) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         type_ff    <= req_type;
         channel_ff <= req_channel;
         level_ff   <= req_level;
         time_us_ff <= req_time_us;
         time_ms_ff <= req_time_ms;
      end
   end

   rcpf_capture #(
      .CHANNELS (CHANNELS)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .edge_en    (edge_en),
      .channel    (channel_ff),
      .level      (level_ff),
      .time_us    (time_us_ff),
      .clear      (poll_en && cap_status.any_fresh),
      .cap_widths (cap_widths),
      .cap_status (cap_status)
   );

   rcpf_failsafe #(
      .CHANNELS (CHANNELS)
   ) u_failsafe (
      .clock          (clock),
      .reset          (reset),
      .poll_en        (poll_en),
      .time_ms        (time_ms_ff),
      .timeout_ms     (timeout_ff),
      .failsafe_value (failsafe_ff),
      .cap_widths     (cap_widths),
      .cap_status     (cap_status),
      .result         (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (poll_en) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (poll_en) begin
         out_ff <= result;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_ch1_width = out_ff.widths[0];
   assign rsp_ch2_width = out_ff.widths[1];
   assign rsp_ch3_width = out_ff.widths[2];
   assign rsp_ch4_width = out_ff.widths[3];
   assign rsp_ch5_width = out_ff.widths[4];
   assign rsp_ch6_width = out_ff.widths[5];
   assign rsp_link_ok   = out_ff.link_ok;
   assign rsp_connected = out_ff.connected;

endmodule

// ===== rtl/rcpf_checker.sv =====
// rcpf_checker: port-level checks of the rc pwm capture and failsafe unit
// depends on rcpf_pkg and binds to rc_pwm_capture_failsafe_unit

module rcpf_checker
   import rcpf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_type,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_link_ok,
   input logic       rsp_connected
);

   // no result item right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result item stays offered
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a lost link is never reported as connected
   a_lost_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_link_ok |-> !rsp_connected)
      else $error("link lost but connected");

   // a poll accepted with an empty output shows a result after the input and result registers
   a_poll_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_POLL) && !rsp_valid
      |=> ##1 rsp_valid)
      else $error("poll result missing");

endmodule

bind rc_pwm_capture_failsafe_unit rcpf_checker u_rcpf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_link_ok   (rsp_link_ok),
   .rsp_connected (rsp_connected)
);

// ===== dv/rcpf_checker.sv =====
// tb_checker: tracks pulse capture and failsafe state from the observed channels,
// computes each poll report and compares it with the result channel
// depends on rcpf_pkg

module tb_checker
   import rcpf_pkg::*;
#(
   parameter int unsigned CHANNELS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [2:0]  req_channel,
   input  logic        req_level,
   input  logic [31:0] req_time_us,
   input  logic [31:0] req_time_ms,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_ch1_width,
   input  logic [15:0] rsp_ch2_width,
   input  logic [15:0] rsp_ch3_width,
   input  logic [15:0] rsp_ch4_width,
   input  logic [15:0] rsp_ch5_width,
   input  logic [15:0] rsp_ch6_width,
   input  logic        rsp_link_ok,
   input  logic        rsp_connected,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          results_owed
);

   // shadow of the block's registers and capture state
   logic [15:0]         timeout_reg;
   logic [15:0]         failsafe_reg;
   logic [31:0]         rise_time [CHANNELS];
   logic [15:0]         pulse_width [CHANNELS];
   logic [CHANNELS-1:0] fresh;
   logic                fresh_any;
   logic [15:0]         held [CHANNELS];
   logic [15:0]         pulse_polls;
   logic [31:0]         window_start;
   logic                link_up;

   // poll reports not yet seen on the result channel
   result_type poll_reports [$];
   int         mism = 0;

   // one accepted item: edges update the capture, polls produce a report
   task automatic update_capture(input logic typ, input logic [2:0] ch, input logic lvl,
                                 input logic [31:0] tus, input logic [31:0] tms);
      result_type  rep;
      logic        ok;
      logic [31:0] elapsed;
      ok = 1'b1;
      if (typ == REQ_EDGE) begin
         // out of range channels are dropped
         if (ch < CHANNELS) begin
            if (lvl) begin
               rise_time[ch] = tus;
            end else begin
               pulse_width[ch] = 16'(tus - rise_time[ch]);
               fresh[ch]       = 1'b1;
               fresh_any       = 1'b1;
            end
         end
         return;
      end
      elapsed = tms - window_start;
      if (fresh_any) begin
         // latch fresh widths and count a pulse poll
         for (int j = 0; j < CHANNELS; j++) begin
            if (fresh[j])
               held[j] = pulse_width[j];
            pulse_width[j] = '0;
         end
         fresh     = '0;
         fresh_any = 1'b0;
         if (pulse_polls != 16'hFFFF)
            pulse_polls++;
      end else if (elapsed > {16'h0, timeout_reg}) begin
         // window expired: failsafe if no pulses came, else connected
         window_start = tms;
         if (pulse_polls == '0) begin
            for (int j = 0; j < CHANNELS; j++)
               held[j] = failsafe_reg;
            link_up = 1'b0;
            ok      = 1'b0;
         end else begin
            pulse_polls = '0;
            link_up     = 1'b1;
         end
      end
      rep.widths = '0;
      for (int j = 0; j < CHANNELS; j++)
         rep.widths[j] = held[j];
      rep.link_ok   = ok;
      rep.connected = link_up;
      poll_reports.push_back(rep);
   endtask

   // compare one accepted result with the oldest report
   task automatic compare_poll_report();
      result_type got;
      result_type want;
      got.widths    = {rsp_ch6_width, rsp_ch5_width, rsp_ch4_width,
                       rsp_ch3_width, rsp_ch2_width, rsp_ch1_width};
      got.link_ok   = rsp_link_ok;
      got.connected = rsp_connected;
      if (poll_reports.size() == 0) begin
         mism++;
         if (mism <= 10)
            $display("unexpected result: widths %h link_ok %b connected %b",
                     got.widths, got.link_ok, got.connected);
         return;
      end
      want = poll_reports.pop_front();
      if (got.widths !== want.widths || got.link_ok !== want.link_ok ||
          got.connected !== want.connected) begin
         mism++;
         if (mism <= 10)
            $display("mismatch: expected widths %h link_ok %b connected %b, ",
                     want.widths, want.link_ok, want.connected,
                     "got widths %h link_ok %b connected %b",
                     got.widths, got.link_ok, got.connected);
      end
   endtask

   // watch all three channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         timeout_reg  = TIMEOUT_RESET;
         failsafe_reg = FAILSAFE_RESET;
         for (int j = 0; j < CHANNELS; j++) begin
            rise_time[j]   = '0;
            pulse_width[j] = '0;
            held[j]        = '0;
         end
         fresh        = '0;
         fresh_any    = 1'b0;
         pulse_polls  = '0;
         window_start = '0;
         link_up      = 1'b0;
         poll_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIMEOUT:  timeout_reg  = csr_wdata;
               CSR_FAILSAFE: failsafe_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall)
            compare_poll_report();
         if (req_valid && !req_stall)
            update_capture(req_type, req_channel, req_level, req_time_us, req_time_ms);
      end
      mismatch_count <= mism;
      results_owed   <= poll_reports.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// tb_top: stimulus and verdict for rc_pwm_capture_failsafe_unit
// depends on rcpf_pkg, the unit and tb_checker

module tb_top
   import rcpf_pkg::*;
;

   localparam int unsigned CHANNELS      = 6;
   localparam int unsigned LIMIT_CYCLES  = 2000000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned HOLD_CYCLES   = 300;
   // indexes with no register behind them
   localparam logic [1:0]  CSR_SPARE_A   = 2'd2;
   localparam logic [1:0]  CSR_SPARE_B   = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [2:0]  req_channel;
   logic        req_level;
   logic [31:0] req_time_us;
   logic [31:0] req_time_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_ch1_width;
   logic [15:0] rsp_ch2_width;
   logic [15:0] rsp_ch3_width;
   logic [15:0] rsp_ch4_width;
   logic [15:0] rsp_ch5_width;
   logic [15:0] rsp_ch6_width;
   logic        rsp_link_ok;
   logic        rsp_connected;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          mismatch_count;
   int          results_owed;

   // sender state
   int unsigned items_sent  = 0;
   int unsigned burst_left  = 0;
   int unsigned cycle_count = 0;
   bit          offering    = 0;
   bit          hold_go     = 0;
   bit          hold_done   = 0;
   logic [15:0] cur_timeout = TIMEOUT_RESET;
   logic [31:0] now_us;
   logic [31:0] now_ms      = '0;

   rc_pwm_capture_failsafe_unit #(.CHANNELS(CHANNELS)) dut (.*);

   tb_checker #(.CHANNELS(CHANNELS)) checker_i (.*);

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // idle length: mostly short, a few long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 15)
         return $urandom_range(1, 3);
      if (r < 19)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // sender gap, with occasional back-to-back bursts
   function automatic int unsigned send_gap();
      int unsigned r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 9);
      if (r == 0)
         burst_left = $urandom_range(10, 40);
      if (r < 5)
         return 0;
      return idle_len();
   endfunction

   // poll time advance, shaped around the current timeout
   function automatic logic [31:0] ms_step();
      logic [31:0] tmo;
      tmo = {16'h0, cur_timeout};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, tmo);
         5: return tmo;
         6: return tmo + 1;
         7: return tmo + $urandom_range(2, 3000);
         8: return '0;
         default: return $urandom;
      endcase
   endfunction

   // pulse width in us, mostly servo range, some beyond 16 bits
   function automatic logic [31:0] pulse_len();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 8)
         return $urandom_range(900, 2100);
      if (r == 8)
         return $urandom_range(0, 65535);
      return $urandom_range(65536, 200000);
   endfunction

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            hold_done = 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (idle_len()) @(posedge clock);
         end
      end
   end

   // offer one item and wait for it to be taken
   task automatic push_item(input logic typ, input logic [2:0] ch, input logic lvl,
                            input logic [31:0] tus, input logic [31:0] tms);
      int unsigned g;
      req_valid   <= 1'b1;
      req_type    <= typ;
      req_channel <= ch;
      req_level   <= lvl;
      req_time_us <= tus;
      req_time_ms <= tms;
      offering = 1;
      do @(posedge clock); while (req_stall);
      if (!(typ == REQ_EDGE && ch >= CHANNELS))
         items_sent++;
      g = send_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         offering = 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic edge_item(input logic [2:0] ch, input logic lvl, input logic [31:0] tus);
      push_item(REQ_EDGE, ch, lvl, tus, $urandom);
   endtask

   task automatic poll_item(input logic [31:0] tms);
      push_item(REQ_POLL, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom, tms);
   endtask

   // drain: wait for every report, then for edges still in flight
   task automatic settle();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 0;
      end
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // write both registers, optionally poking the unused indexes first
   task automatic configure(input logic [15:0] tmo, input logic [15:0] fs, input bit spare);
      if (spare) begin
         csr_beat(CSR_SPARE_A, 16'($urandom));
         csr_beat(CSR_SPARE_B, 16'($urandom));
      end
      csr_beat(CSR_TIMEOUT, tmo);
      csr_beat(CSR_FAILSAFE, fs);
      csr_valid <= 1'b0;
      cur_timeout = tmo;
   endtask

   // one receiver frame: rise and fall on most channels
   task automatic rc_frame();
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if ($urandom_range(0, 4) != 0) begin
            now_us += $urandom_range(1, 5000);
            edge_item(3'(ch), 1'b1, now_us);
            now_us += pulse_len();
            edge_item(3'(ch), 1'b0, now_us);
         end
      end
   endtask

   // mostly frames followed by a poll, the rest bare polls, noise and broken pulses
   task automatic random_traffic(input int unsigned count);
      int unsigned goal;
      int unsigned pick;
      logic [2:0]  ch;
      goal = items_sent + count;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            rc_frame();
            now_ms += ms_step();
            poll_item(now_ms);
         end else if (pick < 15) begin
            repeat ($urandom_range(1, 3)) begin
               now_ms += ms_step();
               poll_item(now_ms);
            end
         end else if (pick < 17) begin
            edge_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom);
         end else if (pick < 19) begin
            // lone rising or lone falling edge
            ch = 3'($urandom_range(0, CHANNELS - 1));
            now_us += pulse_len();
            edge_item(ch, 1'($urandom_range(0, 1)), now_us);
         end else begin
            now_ms = $urandom;
            poll_item(now_ms);
         end
      end
   endtask

   // hand-picked items at the reset register values
   task automatic directed();
      poll_item(32'd0);                          // nothing fresh, window open
      poll_item(32'd101);                        // window expired, no pulses: failsafe
      edge_item(3'd0, 1'b0, 32'h0001_2345);      // fall with no rise
      edge_item(3'd5, 1'b1, 32'hFFFF_FFF0);
      edge_item(3'd5, 1'b0, 32'h0000_0010);      // width across us wrap
      edge_item(3'd6, 1'b1, $urandom);           // out of range channels
      edge_item(3'd7, 1'b0, $urandom);
      edge_item(3'd1, 1'b1, 32'h0000_0000);
      edge_item(3'd1, 1'b0, 32'h0000_FFFF);      // widest width
      edge_item(3'd2, 1'b1, 32'hFFFF_FFFF);
      edge_item(3'd2, 1'b0, 32'hFFFF_FFFF);      // zero width
      edge_item(3'd4, 1'b1, 32'h0000_1000);
      edge_item(3'd4, 1'b0, 32'h0001_1800);      // width truncated to 16 bits
      poll_item(32'hFFFF_FFFF);                  // pulse poll
      poll_item(32'h0000_0000);                  // wrapped diff expired: connected
      poll_item(32'd100);                        // exactly the timeout: no expiry
      poll_item(32'd101);                        // no pulses in window: failsafe
      edge_item(3'd3, 1'b0, 32'd5);              // start time still zero
      poll_item(32'd101);
      poll_item(32'hFFFF_FFF0);
      poll_item(32'h0000_0050);                  // wrapped diff below timeout
      now_ms = 32'h0000_0050;
   endtask

   // main sequence
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = REQ_EDGE;
      req_channel = '0;
      req_level   = 1'b0;
      req_time_us = '0;
      req_time_ms = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_TIMEOUT;
      csr_wdata   = '0;
      now_us      = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed();
      random_traffic(250);

      settle();
      configure(16'd0, 16'd0, 0);
      random_traffic(250);

      settle();
      configure(16'd1, 16'hFFFF, 1);
      random_traffic(250);

      settle();
      configure(16'hFFFF, 16'($urandom), 0);
      now_ms = 32'hFFFF_F000;
      random_traffic(250);

      settle();
      configure(16'($urandom_range(2, 5000)), 16'($urandom), 0);
      hold_go = 1;
      random_traffic(300);

      settle();
      configure(16'd1000, 16'd1500, 0);
      random_traffic(250);

      settle();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
